/* sv/htd_pkg.sv */
// Package for the Huffman tree-walk decoder.
// Holds node-entry type, state encoding, request and register codes.
// No dependencies.
`default_nettype none

package htd_pkg;

    localparam int NODE_COUNT  = 512;
    localparam int IDX_W       = 9;
    localparam int SYMBOL_BITS = 8;
    localparam int CODE_W      = 8;
    localparam int BIT_CNT_W   = $clog2(CODE_W);
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b1;

    typedef struct packed {
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] sym;
        logic [IDX_W-1:0]       right;
        logic [IDX_W-1:0]       left;
    } t_node;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CUR,
        ST_NXT,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

/* sv/huffman_tree_decoder.sv */
// Huffman tree-walk decoder top level: node table memory and walk control; uses htd_pkg.
// A byte holds the input through the request, a step per code bit, a root entry read before
// the first bit and after each symbol not on the last bit (none when the root is a leaf), and
// a flush; result stalls add to it. Loads and bytes after the total leave the decoder idle.
// A new byte waits until the last is flushed; the node table port reads once per cycle.
// Reset: synchronous active low; root, total, count and walk cleared; table undefined.
`default_nettype none

module huffman_tree_decoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // s_axis_tdata: node_slot, left_child, right_child, leaf_mark, leaf_symbol,
    // code_byte, then zero pad
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [htd_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: req_type
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // m_axis_tdata: symbol_out
    output logic [htd_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic                                m_axis_tlast,
    // m_axis_tuser: all_done
    output logic                                m_axis_tuser,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [htd_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [htd_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);

    htd_pkg::t_node mem [htd_pkg::NODE_COUNT];
    htd_pkg::t_node r_q;

    htd_pkg::t_state r_state, n_state;
    logic [htd_pkg::IDX_W-1:0]       r_root, n_root;
    logic [htd_pkg::COUNT_W-1:0]     r_total, n_total;
    logic [htd_pkg::IDX_W-1:0]       r_walk, n_walk;
    logic [htd_pkg::COUNT_W-1:0]     r_count, n_count;
    logic                            r_finished, n_finished;
    htd_pkg::t_node                  r_cur, n_cur;
    logic                            r_cur_mem, n_cur_mem;
    logic                            r_cur_ok, n_cur_ok;
    logic [htd_pkg::IDX_W-1:0]       r_next, n_next;
    logic [htd_pkg::BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [htd_pkg::CODE_W-1:0]      r_byte, n_byte;
    logic                            r_pend_v, n_pend_v;
    logic [htd_pkg::SYMBOL_BITS-1:0] r_pend_sym, n_pend_sym;
    logic                            r_pend_done, n_pend_done;
    logic                            r_out_v, n_out_v;
    logic [htd_pkg::SYMBOL_BITS-1:0] r_out_sym, n_out_sym;
    logic                            r_out_last, n_out_last;
    logic                            r_out_done, n_out_done;

    htd_pkg::t_node                  cur;
    htd_pkg::t_node                  ld_node;
    logic [htd_pkg::IDX_W-1:0]       ld_slot;
    logic [htd_pkg::IDX_W-1:0]       nxt;
    logic [htd_pkg::IDX_W-1:0]       rd_addr;
    logic                            rd_en;
    logic                            wr_en;
    logic                            out_free;
    logic                            emit_stall;
    logic                            do_emit;
    logic [htd_pkg::SYMBOL_BITS-1:0] emit_sym;
    logic [htd_pkg::COUNT_W-1:0]     cnt_inc;
    logic                            hit;
    logic                            s_accept;

    assign ld_slot       = s_axis_tdata[8:0];
    assign ld_node.left  = s_axis_tdata[17:9];
    assign ld_node.right = s_axis_tdata[26:18];
    assign ld_node.leaf  = s_axis_tdata[27];
    assign ld_node.sym   = s_axis_tdata[35:28];

    assign s_axis_tready = (r_state == htd_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s_accept && (s_axis_tuser == htd_pkg::REQ_LOAD);

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[ld_slot] <= ld_node;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_root      = r_root;
        n_total     = r_total;
        n_walk      = r_walk;
        n_count     = r_count;
        n_finished  = r_finished;
        n_cur       = r_cur;
        n_cur_mem   = r_cur_mem;
        n_cur_ok    = r_cur_ok;
        n_next      = r_next;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_pend_v    = r_pend_v;
        n_pend_sym  = r_pend_sym;
        n_pend_done = r_pend_done;
        n_out_v     = r_out_v;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        rd_en       = 1'b0;
        rd_addr     = r_walk;
        do_emit     = 1'b0;
        emit_sym    = r_q.sym;

        cur        = r_cur_mem ? r_q : r_cur;
        nxt        = r_byte[7] ? cur.right : cur.left;
        out_free   = !r_out_v || m_axis_tready;
        emit_stall = r_pend_v && !out_free;
        cnt_inc    = r_count + 32'd1;
        hit        = (cnt_inc == r_total);

        if (r_out_v && m_axis_tready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            htd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser == htd_pkg::REQ_LOAD) begin
                        n_cur_ok  = 1'b0;
                        n_cur_mem = 1'b0;
                    end else if (!r_finished) begin
                        n_byte  = s_axis_tdata[43:36];
                        n_bit   = '1;
                        n_state = htd_pkg::ST_CUR;
                        if (!r_cur_ok) begin
                            rd_en     = 1'b1;
                            rd_addr   = r_walk;
                            n_cur_mem = 1'b1;
                            n_cur_ok  = 1'b1;
                        end
                    end
                end
            end
            htd_pkg::ST_CUR: begin
                n_cur     = cur;
                n_cur_mem = 1'b0;
                if (cur.leaf) begin
                    if (!emit_stall) begin
                        do_emit  = 1'b1;
                        emit_sym = cur.sym;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = nxt;
                    n_next  = nxt;
                    n_state = htd_pkg::ST_NXT;
                end
            end
            htd_pkg::ST_NXT: begin
                if (r_q.leaf) begin
                    if (!emit_stall) begin
                        do_emit  = 1'b1;
                        emit_sym = r_q.sym;
                    end
                end else begin
                    // child becomes the walk position; chain straight into the next bit
                    n_walk    = r_next;
                    n_cur     = r_q;
                    n_cur_mem = 1'b0;
                    n_cur_ok  = 1'b1;
                    if (r_bit == '0) begin
                        n_state = htd_pkg::ST_FLUSH;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_byte  = {r_byte[htd_pkg::CODE_W-2:0], 1'b0};
                        rd_en   = 1'b1;
                        rd_addr = r_byte[6] ? r_q.right : r_q.left;
                        n_next  = r_byte[6] ? r_q.right : r_q.left;
                    end
                end
            end
            htd_pkg::ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = htd_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_v     = 1'b1;
                    n_out_sym   = r_pend_sym;
                    n_out_last  = 1'b1;
                    n_out_done  = r_pend_done;
                    n_pend_v    = 1'b0;
                    n_state     = htd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = htd_pkg::ST_IDLE;
            end
        endcase

        if (do_emit) begin
            // return to the root and fetch its entry for the next bit
            n_walk    = r_root;
            rd_en     = 1'b1;
            rd_addr   = r_root;
            n_cur_mem = 1'b1;
            n_cur_ok  = 1'b1;
            n_count   = cnt_inc;
            if (hit) begin
                n_finished = 1'b1;
            end
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_sym  = r_pend_sym;
                n_out_last = 1'b0;
                n_out_done = r_pend_done;
            end
            n_pend_v    = 1'b1;
            n_pend_sym  = emit_sym;
            n_pend_done = hit;
            if (hit || (r_bit == '0)) begin
                n_state = htd_pkg::ST_FLUSH;
            end else begin
                n_bit   = r_bit - 1'b1;
                n_byte  = {r_byte[htd_pkg::CODE_W-2:0], 1'b0};
                n_state = htd_pkg::ST_CUR;
            end
        end

        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                htd_pkg::CFG_ROOT: begin
                    n_root    = i_cfg_wr_data[htd_pkg::IDX_W-1:0];
                    n_walk    = i_cfg_wr_data[htd_pkg::IDX_W-1:0];
                    n_cur_ok  = 1'b0;
                    n_cur_mem = 1'b0;
                end
                htd_pkg::CFG_TOTAL: begin
                    n_total    = i_cfg_wr_data;
                    n_count    = '0;
                    n_finished = 1'b0;
                    n_walk     = r_root;
                    n_cur_ok   = 1'b0;
                    n_cur_mem  = 1'b0;
                end
                default: begin
                    n_total = r_total;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= htd_pkg::ST_IDLE;
            r_root     <= '0;
            r_total    <= '0;
            r_walk     <= '0;
            r_count    <= '0;
            r_finished <= 1'b0;
            r_cur_mem  <= 1'b0;
            r_cur_ok   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_root     <= n_root;
            r_total    <= n_total;
            r_walk     <= n_walk;
            r_count    <= n_count;
            r_finished <= n_finished;
            r_cur_mem  <= n_cur_mem;
            r_cur_ok   <= n_cur_ok;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_next      <= n_next;
        r_bit       <= n_bit;
        r_byte      <= n_byte;
        r_pend_sym  <= n_pend_sym;
        r_pend_done <= n_pend_done;
        r_out_sym   <= n_out_sym;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
    end

endmodule

`default_nettype wire

/* sv/htd_checker.sv */
// Port-level checker for the Huffman tree-walk decoder, bound to the top level.
// Depends on htd_pkg and huffman_tree_decoder.
`default_nettype none

module htd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic                         s_axis_tuser,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [htd_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic                         m_axis_tlast,
    input wire logic                         m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result request changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("final symbol not marked last of its byte");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == htd_pkg::REQ_LOAD) |=> s_axis_tready)
        else $error("load request left the decoder busy");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
